// ===== src/pss_pkg.sv =====
`default_nettype none

package pss_pkg;

  typedef enum logic [2:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_SURFACE    = 3'd4,
    CFG_BACKGROUND = 3'd5,
    CFG_GAIN       = 3'd6
  } cfg_idx_e;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic signed [10:0] LightXRst     = 11'sd0;
  localparam logic signed [10:0] LightYRst     = -11'sd300;
  localparam logic signed [10:0] LightZRst     = 11'sd400;
  localparam logic [6:0]         RadiusRst     = 7'd100;
  localparam logic [23:0]        SurfaceRst    = 24'h670B9C;
  localparam logic [23:0]        BackgroundRst = 24'h14021F;
  localparam logic [8:0]         GainRst       = 9'd230;

  localparam int unsigned FxFracW    = 14;
  localparam logic [14:0] FxOne      = 15'd16384;
  localparam logic [17:0] AmbientQ12 = 18'd410;
  localparam int unsigned LightShW   = 18;

  localparam int unsigned DivSteps  = 15;
  localparam int unsigned SqrtSteps = 15;

endpackage

`default_nettype wire

// ===== src/pss_delay.sv =====
`default_nettype none

module pss_delay #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] pipe_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= data_i;
      for (int i = 1; i < Depth; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign data_o = pipe_q[Depth-1];

endmodule

`default_nettype wire

// ===== src/pss_div.sv =====
`default_nettype none

module pss_div #(
  parameter int unsigned NumW = 22,
  parameter int unsigned DenW = 7,
  parameter int unsigned QuoW = 15
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [NumW-1:0]        num_i,
  input  logic [DenW-1:0]        den_i,
  input  logic                   neg_i,
  output logic signed [QuoW:0]   quo_o
);

  logic [DenW-1:0] rem_q  [QuoW-1];
  logic [DenW-1:0] den_q  [QuoW-1];
  logic [QuoW-1:0] bits_q [QuoW];
  logic            neg_q  [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] bits_in;
    logic            neg_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in  = DenW'(num_i[NumW-1:QuoW]);
      assign bits_in = num_i[QuoW-1:0];
      assign den_in  = den_i;
      assign neg_in  = neg_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign bits_in = bits_q[i-1];
      assign den_in  = den_q[i-1];
      assign neg_in  = neg_q[i-1];
    end

    assign trial = {rem_in, bits_in[QuoW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bits_q[i] <= {bits_in[QuoW-2:0], ~diff[DenW]};
        neg_q[i]  <= neg_in;
      end
    end

    if (i < QuoW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= diff[DenW] ? trial[DenW-1:0] : diff[DenW-1:0];
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o = neg_q[QuoW-1] ? -$signed({1'b0, bits_q[QuoW-1]})
                               : $signed({1'b0, bits_q[QuoW-1]});

endmodule

`default_nettype wire

// ===== src/pss_isqrt.sv =====
`default_nettype none

module pss_isqrt #(
  parameter int unsigned RootW = 15
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o
);

  logic [RootW:0]     rem_q  [RootW-1];
  logic [2*RootW-1:0] rad_q  [RootW-1];
  logic [RootW-1:0]   root_q [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_step
    logic [RootW:0]     rem_in;
    logic [2*RootW-1:0] rad_in;
    logic [RootW-1:0]   root_in;
    logic [RootW+2:0]   cat;
    logic [RootW+2:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign cat  = {rem_in, rad_in[2*RootW-1 -: 2]};
    assign diff = cat - {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= {root_in[RootW-2:0], ~diff[RootW+2]};
      end
    end

    if (i < RootW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= diff[RootW+2] ? cat[RootW:0] : diff[RootW:0];
          rad_q[i] <= {rad_in[2*RootW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule

`default_nettype wire

// ===== src/phong_sphere_pixel_shader.sv =====
// Phong pixel shader for a single sphere: each request on the input stream carries one pixel
// offset from the screen centre and yields exactly one colour on the output stream, with
// tuser high when the pixel lies on the sphere's disc. The pipeline takes one pixel every
// clock while it is not held. Its depth is set by the light path: a digit-by-digit square
// root for the light distance followed by a restoring divider for the light direction, each
// with one stage per result bit. The normal path, a divider followed by a square root, fits
// beside it. When the output is not taken the whole pipeline holds, so the input is refused
// only while a finished result is waiting. The user must write registers through the
// configuration port only while no pixel is in flight; the block does not enforce this.
`default_nettype none

module phong_sphere_pixel_shader import pss_pkg::*; #(
  parameter int HALF_SCREEN = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // pixel_x [7:0], pixel_y [15:8]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic                m_axis_tuser,   // on_sphere [0]
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned StIn    = 1;
  localparam int unsigned StInDisc = 3;
  localparam int unsigned StLen   = 4;
  localparam int unsigned StNDiv  = StIn + DivSteps;
  localparam int unsigned StRem   = StNDiv + 2;
  localparam int unsigned StM     = StLen + SqrtSteps;
  localparam int unsigned StL     = StM + DivSteps;
  localparam int unsigned StS     = StL + 4;
  localparam int unsigned StSpec  = StS + 6;
  localparam int unsigned StScale = StSpec + 1;
  localparam int unsigned Lat     = StScale + 1;

  logic signed [10:0] light_pos_x_q, light_pos_y_q, light_pos_z_q;
  logic [6:0]         sphere_radius_q;
  logic [23:0]        surface_rgb_q, background_rgb_q;
  logic [8:0]         intensity_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_pos_x_q    <= LightXRst;
      light_pos_y_q    <= LightYRst;
      light_pos_z_q    <= LightZRst;
      sphere_radius_q  <= RadiusRst;
      surface_rgb_q    <= SurfaceRst;
      background_rgb_q <= BackgroundRst;
      intensity_gain_q <= GainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_LIGHT_X:    light_pos_x_q    <= cfg_wdata_i[10:0];
        CFG_LIGHT_Y:    light_pos_y_q    <= cfg_wdata_i[10:0];
        CFG_LIGHT_Z:    light_pos_z_q    <= cfg_wdata_i[10:0];
        CFG_RADIUS:     sphere_radius_q  <= cfg_wdata_i[6:0];
        CFG_SURFACE:    surface_rgb_q    <= cfg_wdata_i[23:0];
        CFG_BACKGROUND: background_rgb_q <= cfg_wdata_i[23:0];
        CFG_GAIN:       intensity_gain_q <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  function automatic logic [14:0] fx_mul(logic [14:0] a, logic [14:0] b);
    logic [29:0] p;
    p = 30'(a) * 30'(b);
    return p[28:14];
  endfunction

  function automatic logic [7:0] shade(logic [7:0] c, logic [18:0] scaled);
    logic [26:0] p;
    p = 27'(c) * 27'(scaled);
    return (p[26:12] > 15'd255) ? 8'hFF : p[19:12];
  endfunction

  logic           advance;
  logic [Lat:1]   vld_q;

  assign advance       = ~vld_q[Lat] | m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = vld_q[Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[Lat-1:1], s_axis_tvalid};
    end
  end

  logic signed [7:0]  x1_q, y1_q;
  logic [7:0]         abs_x1, abs_y1;
  logic               on_screen1;
  logic [15:0]        xx2_q, yy2_q;
  logic [13:0]        rr2_q;
  logic               os2_q;
  logic signed [11:0] dx2_q, dy2_q, dx3_q, dy3_q, dx4_q, dy4_q;
  logic               inside3_q;
  logic [20:0]        sqx3_q, sqy3_q, sqz3_q;
  logic [29:0]        lensq4_q;

  assign abs_x1 = x1_q[7] ? 8'(-x1_q) : 8'(x1_q);
  assign abs_y1 = y1_q[7] ? 8'(-y1_q) : 8'(y1_q);
  assign on_screen1 = (int'(x1_q) >= -HALF_SCREEN) && (int'(x1_q) < HALF_SCREEN) &&
                      (int'(y1_q) >= -HALF_SCREEN) && (int'(y1_q) < HALF_SCREEN);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x1_q      <= s_axis_tdata[7:0];
      y1_q      <= s_axis_tdata[15:8];
      xx2_q     <= 16'(x1_q * x1_q);
      yy2_q     <= 16'(y1_q * y1_q);
      rr2_q     <= 14'(sphere_radius_q * sphere_radius_q);
      os2_q     <= on_screen1;
      dx2_q     <= 12'(light_pos_x_q) - 12'(x1_q);
      dy2_q     <= 12'(light_pos_y_q) - 12'(y1_q);
      inside3_q <= os2_q && (sphere_radius_q != '0) &&
                   (17'(xx2_q) + 17'(yy2_q) <= 17'(rr2_q));
      sqx3_q    <= 21'(dx2_q * dx2_q);
      sqy3_q    <= 21'(dy2_q * dy2_q);
      sqz3_q    <= 21'(light_pos_z_q * light_pos_z_q);
      dx3_q     <= dx2_q;
      dy3_q     <= dy2_q;
      lensq4_q  <= {22'(sqx3_q) + 22'(sqy3_q) + 22'(sqz3_q), 8'd0};
      dx4_q     <= dx3_q;
      dy4_q     <= dy3_q;
    end
  end

  // Surface normal: x and y by division, z by square root.
  logic signed [15:0] nx_div, ny_div;
  logic signed [15:0] nx17_q, ny17_q, nx18_q, ny18_q;
  logic [28:0]        nxx17_q, nyy17_q;
  logic signed [30:0] nrem17;
  logic [29:0]        rad18_q;
  logic [14:0]        nz_root;

  pss_div #(.NumW(8 + FxFracW), .DenW(7), .QuoW(DivSteps)) u_div_nx (
    .clk_i, .en_i(advance), .num_i({abs_x1, FxFracW'(0)}), .den_i(sphere_radius_q),
    .neg_i(x1_q[7]), .quo_o(nx_div)
  );

  pss_div #(.NumW(8 + FxFracW), .DenW(7), .QuoW(DivSteps)) u_div_ny (
    .clk_i, .en_i(advance), .num_i({abs_y1, FxFracW'(0)}), .den_i(sphere_radius_q),
    .neg_i(y1_q[7]), .quo_o(ny_div)
  );

  assign nrem17 = 31'sd268435456 - $signed({2'b00, nxx17_q}) - $signed({2'b00, nyy17_q});

  always_ff @(posedge clk_i) begin
    if (advance) begin
      nxx17_q <= 29'(nx_div * nx_div);
      nyy17_q <= 29'(ny_div * ny_div);
      nx17_q  <= nx_div;
      ny17_q  <= ny_div;
      rad18_q <= (nrem17 > 0) ? 30'(nrem17) : '0;
      nx18_q  <= nx17_q;
      ny18_q  <= ny17_q;
    end
  end

  pss_isqrt #(.RootW(SqrtSteps)) u_sqrt_nz (
    .clk_i, .en_i(advance), .rad_i(rad18_q), .root_o(nz_root)
  );

  // Light direction: length by square root, then three divisions.
  logic [14:0]        m_len;
  logic [14:0]        m_den;
  logic [23:0]        d_m;
  logic signed [11:0] dx_m, dy_m;
  logic [10:0]        abs_dx, abs_dy, abs_dz;
  logic signed [15:0] lx_div, ly_div, lz_div;
  logic [31:0]        n_l;
  logic signed [15:0] nx_l, ny_l;

  pss_isqrt #(.RootW(SqrtSteps)) u_sqrt_len (
    .clk_i, .en_i(advance), .rad_i(lensq4_q), .root_o(m_len)
  );

  pss_delay #(.Width(24), .Depth(StM - StLen)) u_dly_d (
    .clk_i, .en_i(advance), .data_i({dx4_q, dy4_q}), .data_o(d_m)
  );

  assign dx_m   = d_m[23:12];
  assign dy_m   = d_m[11:0];
  assign abs_dx = dx_m[11] ? 11'(-dx_m) : 11'(dx_m);
  assign abs_dy = dy_m[11] ? 11'(-dy_m) : 11'(dy_m);
  assign abs_dz = light_pos_z_q[10] ? 11'(-light_pos_z_q) : 11'(light_pos_z_q);
  assign m_den  = (m_len == '0) ? 15'd1 : m_len;

  pss_div #(.NumW(11 + LightShW), .DenW(15), .QuoW(DivSteps)) u_div_lx (
    .clk_i, .en_i(advance), .num_i({abs_dx, LightShW'(0)}), .den_i(m_den),
    .neg_i(dx_m[11]), .quo_o(lx_div)
  );

  pss_div #(.NumW(11 + LightShW), .DenW(15), .QuoW(DivSteps)) u_div_ly (
    .clk_i, .en_i(advance), .num_i({abs_dy, LightShW'(0)}), .den_i(m_den),
    .neg_i(dy_m[11]), .quo_o(ly_div)
  );

  pss_div #(.NumW(11 + LightShW), .DenW(15), .QuoW(DivSteps)) u_div_lz (
    .clk_i, .en_i(advance), .num_i({abs_dz, LightShW'(0)}), .den_i(m_den),
    .neg_i(light_pos_z_q[10]), .quo_o(lz_div)
  );

  pss_delay #(.Width(32), .Depth(StL - StRem)) u_dly_n (
    .clk_i, .en_i(advance), .data_i({nx18_q, ny18_q}), .data_o(n_l)
  );

  assign nx_l = n_l[31:16];
  assign ny_l = n_l[15:0];

  // Lighting terms.
  logic [14:0]        nz34_q, nz35_q, nz36_q;
  logic signed [31:0] px35_q, py35_q, pz35_q;
  logic signed [15:0] lz35_q, lz36_q, lz37_q;
  logic signed [33:0] dot_sum;
  logic signed [19:0] dot36_q;
  logic signed [35:0] t37_q;
  logic [18:0]        diffuse37_q, diffuse38_q, diffuse44;
  logic signed [23:0] rz37;
  logic [14:0]        s38_q, s2_q, s4_q, s8_q, s8b_q, s8c_q, s16_q, s32_q, spec44_q;
  logic [17:0]        base44;
  logic [18:0]        scaled45_q;
  logic               inside45;
  logic [23:0]        out_rgb_q;
  logic               out_on_q;

  assign dot_sum = 34'(px35_q) + 34'(py35_q) + 34'(pz35_q);
  assign rz37    = 24'(t37_q >>> 13) - 24'(lz37_q);
  assign base44  = 18'((20'(diffuse44) + 20'(spec44_q)) >> 2) + AmbientQ12;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      nz34_q      <= nz_root;
      px35_q      <= 32'(nx_l * lx_div);
      py35_q      <= 32'(ny_l * ly_div);
      pz35_q      <= 32'($signed({1'b0, nz34_q}) * lz_div);
      nz35_q      <= nz34_q;
      lz35_q      <= lz_div;
      dot36_q     <= dot_sum[33:14];
      nz36_q      <= nz35_q;
      lz36_q      <= lz35_q;
      t37_q       <= 36'(dot36_q * $signed({1'b0, nz36_q}));
      diffuse37_q <= dot36_q[19] ? '0 : dot36_q[18:0];
      lz37_q      <= lz36_q;
      s38_q       <= (rz37 < 0) ? '0 : ((rz37 > 24'(FxOne)) ? FxOne : rz37[14:0]);
      diffuse38_q <= diffuse37_q;
      s2_q        <= fx_mul(s38_q, s38_q);
      s4_q        <= fx_mul(s2_q, s2_q);
      s8_q        <= fx_mul(s4_q, s4_q);
      s16_q       <= fx_mul(s8_q, s8_q);
      s8b_q       <= s8_q;
      s32_q       <= fx_mul(s16_q, s16_q);
      s8c_q       <= s8b_q;
      spec44_q    <= fx_mul(s32_q, s8c_q);
      scaled45_q  <= 19'((27'(base44) * 27'(intensity_gain_q)) >> 8);
      out_on_q    <= inside45;
      out_rgb_q   <= inside45 ? {shade(surface_rgb_q[7:0], scaled45_q),
                                 shade(surface_rgb_q[15:8], scaled45_q),
                                 shade(surface_rgb_q[23:16], scaled45_q)}
                              : {background_rgb_q[7:0], background_rgb_q[15:8],
                                 background_rgb_q[23:16]};
    end
  end

  pss_delay #(.Width(19), .Depth(StSpec - StS)) u_dly_diffuse (
    .clk_i, .en_i(advance), .data_i(diffuse38_q), .data_o(diffuse44)
  );

  pss_delay #(.Width(1), .Depth(StScale - StInDisc)) u_dly_inside (
    .clk_i, .en_i(advance), .data_i(inside3_q), .data_o(inside45)
  );

  assign m_axis_tdata = out_rgb_q;
  assign m_axis_tuser = out_on_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  a_bg_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      (m_axis_tdata[7:0] == background_rgb_q[23:16]) &&
      (m_axis_tdata[15:8] == background_rgb_q[15:8]) &&
      (m_axis_tdata[23:16] == background_rgb_q[7:0]))
    else $error("background result differs from the background colour");

  a_disc_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StInDisc] && inside3_q |-> sphere_radius_q != '0)
    else $error("pixel marked on the disc with zero radius");

  a_spec_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StS] |-> s38_q <= FxOne)
    else $error("reflection term above one");

endmodule

`default_nettype wire

// ===== test/phong_checker.sv =====
`timescale 1ns / 1ps

module phong_checker import pss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [23:0]         m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       on_sphere;
  } colour_t;

  logic signed [10:0] light_x;
  logic signed [10:0] light_y;
  logic signed [10:0] light_z;
  logic [6:0]         radius;
  logic [23:0]        surface;
  logic [23:0]        background;
  logic [8:0]         gain;

  colour_t colour_q[$];

  assign pending_o = colour_q.size();

  function automatic longint int_sqrt(longint v);
    longint res;
    longint bitv;
    res  = 0;
    bitv = longint'(1) << 30;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint fx_product(longint a, longint b);
    return (a * b) >>> 14;
  endfunction

  function automatic logic [7:0] tint(logic [7:0] c, longint scl);
    longint v;
    v = (longint'(c) * scl) >>> 12;
    if (v > 255) v = 255;
    if (v < 0) v = 0;
    return v[7:0];
  endfunction

  function automatic colour_t shade_pixel(logic signed [7:0] px, logic signed [7:0] py);
    colour_t res;
    longint x, y, r, nx, ny, rem, nz, dx, dy, dz, m, lx, ly, lz;
    longint dp, diffuse, rz, s, s2, s4, s8, s16, s32, spec, base, scl;
    x = longint'(px);
    y = longint'(py);
    r = longint'(radius);
    if (r == 0 || x * x + y * y > r * r) begin
      res.red       = background[23:16];
      res.green     = background[15:8];
      res.blue      = background[7:0];
      res.on_sphere = 1'b0;
      return res;
    end
    nx  = (x * 16384) / r;
    ny  = (y * 16384) / r;
    rem = (longint'(1) << 28) - nx * nx - ny * ny;
    nz  = int_sqrt(rem > 0 ? rem : 0);
    dx  = longint'(light_x) - x;
    dy  = longint'(light_y) - y;
    dz  = longint'(light_z);
    m   = int_sqrt((dx * dx + dy * dy + dz * dz) << 8);
    lx  = 0;
    ly  = 0;
    lz  = 0;
    if (m != 0) begin
      lx = (dx * 262144) / m;
      ly = (dy * 262144) / m;
      lz = (dz * 262144) / m;
    end
    dp      = (nx * lx + ny * ly + nz * lz) >>> 14;
    diffuse = dp > 0 ? dp : 0;
    rz      = ((2 * dp * nz) >>> 14) - lz;
    s       = rz < 0 ? 0 : (rz > 16384 ? 16384 : rz);
    s2      = fx_product(s, s);
    s4      = fx_product(s2, s2);
    s8      = fx_product(s4, s4);
    s16     = fx_product(s8, s8);
    s32     = fx_product(s16, s16);
    spec    = fx_product(s32, s8);
    base    = ((diffuse + spec) >>> 2) + 410;
    scl     = (base * longint'(gain)) >>> 8;
    res.red       = tint(surface[23:16], scl);
    res.green     = tint(surface[15:8], scl);
    res.blue      = tint(surface[7:0], scl);
    res.on_sphere = 1'b1;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x    <= LightXRst;
      light_y    <= LightYRst;
      light_z    <= LightZRst;
      radius     <= RadiusRst;
      surface    <= SurfaceRst;
      background <= BackgroundRst;
      gain       <= GainRst;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        colour_q.push_back(shade_pixel(s_axis_tdata[7:0], s_axis_tdata[15:8]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        colour_t want;
        if (colour_q.size() == 0) begin
          report("unexpected result", int'(m_axis_tdata), 0);
        end else begin
          want = colour_q.pop_front();
          if (m_axis_tdata[7:0] !== want.red) begin
            report("red", int'(m_axis_tdata[7:0]), int'(want.red));
          end
          if (m_axis_tdata[15:8] !== want.green) begin
            report("green", int'(m_axis_tdata[15:8]), int'(want.green));
          end
          if (m_axis_tdata[23:16] !== want.blue) begin
            report("blue", int'(m_axis_tdata[23:16]), int'(want.blue));
          end
          if (m_axis_tuser !== want.on_sphere) begin
            report("on_sphere", int'(m_axis_tuser), int'(want.on_sphere));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_LIGHT_X:    light_x    <= cfg_wdata_i[10:0];
          CFG_LIGHT_Y:    light_y    <= cfg_wdata_i[10:0];
          CFG_LIGHT_Z:    light_z    <= cfg_wdata_i[10:0];
          CFG_RADIUS:     radius     <= cfg_wdata_i[6:0];
          CFG_SURFACE:    surface    <= cfg_wdata_i[23:0];
          CFG_BACKGROUND: background <= cfg_wdata_i[23:0];
          CFG_GAIN:       gain       <= cfg_wdata_i[8:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench import pss_pkg::*;;

  localparam int CycleLimit = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int                  fail_count;
  int                  pending;
  int                  cycles;
  int                  hold_cycles;
  bit                  eager_sink;
  bit                  eager_source;
  int                  cur_radius;

  phong_sphere_pixel_shader dut (.*);

  phong_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 13) return 0;
    if (pick < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // The sink holds off on its own count whenever hold_cycles is loaded.
  initial begin
    m_axis_tready = 1'b0;
    hold_cycles   = 0;
    eager_sink    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        hold_cycles--;
      end else if (eager_sink) begin
        m_axis_tready = 1'b1;
      end else begin
        int g;
        g = gap_len();
        if (g == 0) begin
          m_axis_tready = 1'b1;
        end else begin
          m_axis_tready = 1'b0;
          hold_cycles   = g - 1;
        end
      end
    end
  end

  task automatic send_pixel(logic [7:0] x, logic [7:0] y);
    int g;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    g = eager_source ? 0 : gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = 16'($urandom());
      repeat (g - 1) @(negedge clk_i);
    end
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    if (idx == CFG_RADIUS) cur_radius = int'(value[6:0]);
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = CfgDataW'($urandom());
  endtask

  task automatic set_light(int lx, int ly, int lz);
    write_reg(CFG_LIGHT_X, CfgDataW'(lx));
    write_reg(CFG_LIGHT_Y, CfgDataW'(ly));
    write_reg(CFG_LIGHT_Z, CfgDataW'(lz));
  endtask

  function automatic logic [7:0] coord();
    int v;
    if ($urandom_range(0, 4) == 0) return 8'($urandom());
    v = $urandom_range(0, 2 * cur_radius + 2) - cur_radius - 1;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return 8'(v);
  endfunction

  task automatic random_pixels(int count);
    eager_source = $urandom_range(0, 3) == 0;
    eager_sink   = $urandom_range(0, 3) == 0;
    repeat (count) send_pixel(coord(), coord());
    eager_source = 1'b0;
    eager_sink   = 1'b0;
  endtask

  function automatic int light_value();
    case ($urandom_range(0, 5))
      0:       return -1024;
      1:       return 1023;
      default: return $urandom_range(0, 2047) - 1024;
    endcase
  endfunction

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    eager_source  = 1'b0;
    cur_radius    = 100;
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_pixel(8'd0, 8'd0);
    send_pixel(8'd127, 8'd127);
    send_pixel(8'h80, 8'h80);
    send_pixel(8'd127, 8'h80);
    send_pixel(8'h80, 8'd127);
    send_pixel(8'd100, 8'd0);
    send_pixel(8'd101, 8'd0);
    send_pixel(8'd0, -8'sd100);
    send_pixel(8'd60, 8'd80);
    send_pixel(8'd61, 8'd80);
    send_pixel(8'd0, -8'sd60);
    send_pixel(-8'sd30, 8'd20);
    settle();

    // Light sitting on the surface point itself, then the light on the view axis.
    set_light(10, 20, 0);
    send_pixel(8'd10, 8'd20);
    send_pixel(8'd11, 8'd20);
    settle();
    set_light(0, 0, 1023);
    write_reg(CFG_SURFACE, 24'hFFFFFF);
    write_reg(CFG_BACKGROUND, 24'h000000);
    write_reg(CFG_GAIN, 24'd511);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd1, 8'd2);
    send_pixel(8'd120, 8'd0);
    settle();
    write_reg(CFG_RADIUS, 24'd0);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd1, 8'd0);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      set_light(light_value(), light_value(), light_value());
      case (phase)
        0:       write_reg(CFG_RADIUS, 24'd127);
        1:       write_reg(CFG_RADIUS, 24'd1);
        2:       write_reg(CFG_RADIUS, 24'd0);
        default: write_reg(CFG_RADIUS, CfgDataW'($urandom_range(1, 127)));
      endcase
      case (phase)
        3:       write_reg(CFG_SURFACE, 24'h000000);
        4:       write_reg(CFG_SURFACE, 24'hFFFFFF);
        default: write_reg(CFG_SURFACE, CfgDataW'($urandom_range(0, 24'hFFFFFF)));
      endcase
      write_reg(CFG_BACKGROUND,
                phase == 5 ? 24'hFFFFFF : CfgDataW'($urandom_range(0, 24'hFFFFFF)));
      case (phase)
        5:       write_reg(CFG_GAIN, 24'd0);
        6:       write_reg(CFG_GAIN, 24'd511);
        default: write_reg(CFG_GAIN, CfgDataW'($urandom_range(0, 511)));
      endcase
      if (phase == 4) begin
        random_pixels(40);
        hold_cycles = 300;
        eager_source = 1'b1;
        repeat (100) send_pixel(coord(), coord());
        eager_source = 1'b0;
        random_pixels(50);
      end else begin
        random_pixels(190);
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
